### src/srf_pkg.sv
// srf_pkg: shared sizes, action and status codes, and the scan token and
// broadcast types of the searchable ring FIFO.
// No dependencies.
package srf_pkg;

   localparam int DEPTH  = 16;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int WORD_W = 32;
   localparam int ACT_W  = 3;
   localparam int STAT_W = 2;

   localparam logic [ACT_W-1:0] ACT_ENQUEUE = 3'd0;
   localparam logic [ACT_W-1:0] ACT_DEQUEUE = 3'd1;
   localparam logic [ACT_W-1:0] ACT_PEEK    = 3'd2;
   localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd3;
   localparam logic [ACT_W-1:0] ACT_SEARCH  = 3'd4;

   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd2;
   localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

   // Search token passed cell to cell: best match seen so far.
   typedef struct packed {
      logic             valid;
      logic             hit;
      logic [IDX_W-1:0] pos;
      logic [IDX_W-1:0] slot;
   } token_type;

   // Queue state and key broadcast to every cell during a scan.
   typedef struct packed {
      logic [IDX_W-1:0]         head;
      logic [CNT_W-1:0]         cap;
      logic [CNT_W-1:0]         fill;
      logic signed [WORD_W-1:0] key;
   } scan_ctl_type;

endpackage

### src/srf_cell.sv
// srf_cell: one storage slot of the ring FIFO with its own key comparator.
// Depends on srf_pkg.
module srf_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [srf_pkg::IDX_W-1:0]         cell_idx,
   input  logic                              wr_en,
   input  logic signed [srf_pkg::WORD_W-1:0] wr_data,
   input  srf_pkg::scan_ctl_type             scan_ctl,
   input  srf_pkg::token_type                tok_in,
   output srf_pkg::token_type                tok_out,
   output logic signed [srf_pkg::WORD_W-1:0] word_out
);
   import srf_pkg::*;

   logic signed [WORD_W-1:0] word_ff;
   token_type                tok_ff;
   token_type                tok_in_next;
   logic [CNT_W-1:0]         idx_ext;
   logic [CNT_W-1:0]         head_ext;
   logic [CNT_W-1:0]         pos_wide;
   logic [IDX_W-1:0]         pos;
   logic                     held;
   logic                     own_hit;
   logic                     take;

   // distance of this slot from head, wrapping at the active capacity
   always_comb begin
      idx_ext  = CNT_W'(cell_idx);
      head_ext = CNT_W'(scan_ctl.head);
      if (idx_ext >= head_ext) begin
         pos_wide = idx_ext - head_ext;
      end else begin
         pos_wide = idx_ext + scan_ctl.cap - head_ext;
      end
      pos     = pos_wide[IDX_W-1:0];
      held    = (idx_ext < scan_ctl.cap) && (pos_wide < scan_ctl.fill);
      own_hit = tok_in.valid && held && (word_ff == scan_ctl.key);
      take    = own_hit && (!tok_in.hit || (pos < tok_in.pos));

      tok_in_next       = tok_in;
      tok_in_next.hit   = tok_in.hit || own_hit;
      if (take) begin
         tok_in_next.pos  = pos;
         tok_in_next.slot = cell_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         word_ff <= wr_data;
      end
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   assign tok_out  = tok_ff;
   assign word_out = word_ff;

endmodule

### src/searchable_ring_fifo.sv
// searchable_ring_fifo: top level, control, result register and the row
// of slot cells. Depends on srf_pkg and srf_cell.
//
// Usage
//   Request channel: drive req_action and req_value and raise start; the
//   item is taken at a rising edge where start is high and busy is low.
//   Actions: enqueue, dequeue, peek, clear, search. Codes 5..7 change
//   nothing and answer ok with count and flags.
//   Response channel: each item yields exactly one result, shown on the
//   rsp_ ports for one cycle with rsp_strobe high. The receiver cannot
//   stall; it must take the result in that cycle.
//   Config: csr_wen with csr_wdata writes the capacity (0 acts as 1,
//   above DEPTH acts as DEPTH) and empties the queue. Write only while
//   busy is low and no result is pending.
// Timing
//   Enqueue, dequeue, peek, clear and unused codes: result in the cycle
//   after acceptance; busy stays low, so one such item per clock.
//   Search: a token walks the row of DEPTH cells, one cell per clock,
//   each cell folding in its own comparison. busy is high until the
//   result appears, so no other item is taken while a search runs.
// Reset
//   Synchronous, active high: head, tail and fill go to zero, capacity
//   to DEPTH, no result pending. Stored words are not cleared; a slot is
//   only read once it holds an entry.
module searchable_ring_fifo (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [srf_pkg::ACT_W-1:0]         req_action,
   input  logic signed [srf_pkg::WORD_W-1:0] req_value,
   output logic                              rsp_strobe,
   output logic [srf_pkg::STAT_W-1:0]        rsp_status,
   output logic signed [srf_pkg::WORD_W-1:0] rsp_data_out,
   output logic [srf_pkg::IDX_W-1:0]         rsp_found_slot,
   output logic [srf_pkg::IDX_W-1:0]         rsp_found_position,
   output logic [srf_pkg::CNT_W-1:0]         rsp_count,
   output logic                              rsp_is_empty,
   output logic                              rsp_is_full,
   input  logic                              csr_wen,
   input  logic [srf_pkg::CNT_W-1:0]         csr_wdata
);
   import srf_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   // control state
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cap_ff, cap_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             inj_ff, inj_in;
   logic signed [WORD_W-1:0] key_ff, key_in;

   // registered result
   logic                     strobe_ff, strobe_in;
   logic [STAT_W-1:0]        status_ff, status_in;
   logic signed [WORD_W-1:0] data_ff, data_in;
   logic [IDX_W-1:0]         slot_ff, slot_in;
   logic [IDX_W-1:0]         pos_ff, pos_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     empty_ff, empty_in;
   logic                     full_ff, full_in;

   logic [CNT_W-1:0]         cap_eff;
   logic                     accept;
   logic                     enq_ok;
   logic signed [WORD_W-1:0] head_word;
   logic [DEPTH:0]           tok_valids;

   token_type                tok [DEPTH+1];
   logic signed [WORD_W-1:0] words [DEPTH];
   scan_ctl_type             scan_ctl;

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] p,
                                                  input logic [CNT_W-1:0] cap);
      logic [CNT_W-1:0] p1;
      p1 = CNT_W'(p) + CNT_W'(1);
      return (p1 >= cap) ? '0 : p1[IDX_W-1:0];
   endfunction

   // capacity clamp: zero behaves as one, oversize as DEPTH
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CNT_W'(1);
      end else if (cap_ff > CNT_W'(DEPTH)) begin
         cap_eff = CNT_W'(DEPTH);
      end else begin
         cap_eff = cap_ff;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign enq_ok    = accept && (req_action == ACT_ENQUEUE) && (fill_ff < cap_eff);
   assign head_word = words[head_ff];

   // key holds still for the whole scan; head and fill do too unless csr_wen is raised mid-scan
   assign scan_ctl.head = head_ff;
   assign scan_ctl.cap  = cap_eff;
   assign scan_ctl.fill = fill_ff;
   assign scan_ctl.key  = key_ff;

   // token enters the first cell the cycle after a search is taken
   assign tok[0].valid = inj_ff;
   assign tok[0].hit   = 1'b0;
   assign tok[0].pos   = '0;
   assign tok[0].slot  = '0;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      srf_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (IDX_W'(g)),
         .wr_en    (enq_ok && (tail_ff == IDX_W'(g))),
         .wr_data  (req_value),
         .scan_ctl (scan_ctl),
         .tok_in   (tok[g]),
         .tok_out  (tok[g+1]),
         .word_out (words[g])
      );
   end

   always_comb begin
      for (int k = 0; k <= DEPTH; k++) begin
         tok_valids[k] = tok[k].valid;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cap_in    = cap_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      fill_in   = fill_ff;
      inj_in    = 1'b0;
      key_in    = key_ff;
      strobe_in = 1'b0;
      status_in = STAT_OK;
      data_in   = '0;
      slot_in   = '0;
      pos_in    = '0;
      count_in  = count_ff;
      empty_in  = empty_ff;
      full_in   = full_ff;

      if (csr_wen) begin
         // new capacity empties the queue
         cap_in  = csr_wdata;
         head_in = '0;
         tail_in = '0;
         fill_in = '0;
      end else if (accept) begin
         strobe_in = 1'b1;
         case (req_action)
            ACT_ENQUEUE: begin
               if (fill_ff >= cap_eff) begin
                  status_in = STAT_FULL;
               end else begin
                  tail_in = next_slot(tail_ff, cap_eff);
                  fill_in = fill_ff + CNT_W'(1);
               end
            end
            ACT_DEQUEUE: begin
               if (fill_ff == '0) begin
                  status_in = STAT_EMPTY;
               end else begin
                  data_in = head_word;
                  head_in = next_slot(head_ff, cap_eff);
                  fill_in = fill_ff - CNT_W'(1);
               end
            end
            ACT_PEEK: begin
               if (fill_ff == '0) begin
                  status_in = STAT_EMPTY;
               end else begin
                  data_in = head_word;
               end
            end
            ACT_CLEAR: begin
               head_in = '0;
               tail_in = '0;
               fill_in = '0;
            end
            ACT_SEARCH: begin
               strobe_in = 1'b0;
               key_in    = req_value;
               inj_in    = 1'b1;
               state_in  = S_SCAN;
            end
            default: begin
            end
         endcase
         count_in = fill_in;
         empty_in = (fill_in == '0);
         full_in  = (fill_in == cap_eff);
      end else if ((state_ff == S_SCAN) && tok[DEPTH].valid) begin
         // token left the last cell: report the earliest match
         strobe_in = 1'b1;
         state_in  = S_IDLE;
         if (tok[DEPTH].hit) begin
            slot_in = tok[DEPTH].slot;
            pos_in  = tok[DEPTH].pos;
         end else begin
            status_in = STAT_NOT_FOUND;
         end
         count_in = fill_ff;
         empty_in = (fill_ff == '0);
         full_in  = (fill_ff == cap_eff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cap_ff    <= CNT_W'(DEPTH);
         head_ff   <= '0;
         tail_ff   <= '0;
         fill_ff   <= '0;
         inj_ff    <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cap_ff    <= cap_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         fill_ff   <= fill_in;
         inj_ff    <= inj_in;
         strobe_ff <= strobe_in;
      end
      key_ff    <= key_in;
      status_ff <= status_in;
      data_ff   <= data_in;
      slot_ff   <= slot_in;
      pos_ff    <= pos_in;
      count_ff  <= count_in;
      empty_ff  <= empty_in;
      full_ff   <= full_in;
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_status         = status_ff;
   assign rsp_data_out       = data_ff;
   assign rsp_found_slot     = slot_ff;
   assign rsp_found_position = pos_ff;
   assign rsp_count          = count_ff;
   assign rsp_is_empty       = empty_ff;
   assign rsp_is_full        = full_ff;

   // fill never runs past the active capacity
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= cap_eff)
      else $error("fill above capacity");

   // at most one search token anywhere in the row
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_valids))
      else $error("more than one search token in flight");

   // a token reaching the end of the row belongs to a running scan
   a_token_in_scan: assert property (@(posedge clock) disable iff (reset)
      tok[DEPTH].valid |-> (state_ff == S_SCAN))
      else $error("stray search token");

   // no result is shown while a scan is still running
   a_no_rsp_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> !strobe_ff)
      else $error("result during scan");

endmodule

### tb/searchable_ring_fifo_checker.sv
// searchable_ring_fifo_checker: watches the request, response and capacity
// ports, predicts every response of the ring FIFO and compares field by field.
// Depends on srf_pkg.
module searchable_ring_fifo_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic [srf_pkg::ACT_W-1:0]         req_action,
   input  logic signed [srf_pkg::WORD_W-1:0] req_value,
   input  logic                              rsp_strobe,
   input  logic [srf_pkg::STAT_W-1:0]        rsp_status,
   input  logic signed [srf_pkg::WORD_W-1:0] rsp_data_out,
   input  logic [srf_pkg::IDX_W-1:0]         rsp_found_slot,
   input  logic [srf_pkg::IDX_W-1:0]         rsp_found_position,
   input  logic [srf_pkg::CNT_W-1:0]         rsp_count,
   input  logic                              rsp_is_empty,
   input  logic                              rsp_is_full,
   input  logic                              csr_wen,
   input  logic [srf_pkg::CNT_W-1:0]         csr_wdata,
   output int                                pending,
   output int                                fail_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import srf_pkg::*;

   typedef struct packed {
      logic [STAT_W-1:0]         status;
      logic signed [WORD_W-1:0]  data_out;
      logic [IDX_W-1:0]          slot;
      logic [IDX_W-1:0]          position;
      logic [CNT_W-1:0]          count;
      logic                      is_empty;
      logic                      is_full;
   } fifo_result_type;

   // Shadow copy of the queue.
   logic signed [WORD_W-1:0] ring_words [DEPTH];
   int                       ring_head;
   int                       ring_tail;
   int                       ring_fill;
   logic [CNT_W-1:0]         capacity_reg;

   fifo_result_type          awaited_results [$];

   initial begin
      pending    = 0;
      fail_count = 0;
   end

   function automatic int slots_in_use();
      if (capacity_reg == 0)
         return 1;
      if (capacity_reg > DEPTH)
         return DEPTH;
      return int'(capacity_reg);
   endfunction

   function automatic int wrap_advance(input int p, input int lim);
      return (p + 1 >= lim) ? 0 : p + 1;
   endfunction

   // Applies one request to the shadow queue and returns its response.
   function automatic fifo_result_type apply_request(input logic [ACT_W-1:0] act,
                                                     input logic signed [WORD_W-1:0] key);
      fifo_result_type r;
      int              lim;
      int              idx;
      logic            hit;
      r      = '0;
      r.status = STAT_OK;
      lim    = slots_in_use();
      case (act)
         ACT_ENQUEUE: begin
            if (ring_fill >= lim) begin
               r.status = STAT_FULL;
            end else begin
               ring_words[IDX_W'(ring_tail)] = key;
               ring_tail = wrap_advance(ring_tail, lim);
               ring_fill++;
            end
         end
         ACT_DEQUEUE: begin
            if (ring_fill == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               r.data_out = ring_words[IDX_W'(ring_head)];
               ring_head = wrap_advance(ring_head, lim);
               ring_fill--;
            end
         end
         ACT_PEEK: begin
            if (ring_fill == 0)
               r.status = STAT_EMPTY;
            else
               r.data_out = ring_words[IDX_W'(ring_head)];
         end
         ACT_CLEAR: begin
            ring_head = 0;
            ring_tail = 0;
            ring_fill = 0;
         end
         ACT_SEARCH: begin
            hit = 1'b0;
            idx = ring_head;
            for (int i = 0; i < ring_fill; i++) begin
               if (!hit && ring_words[IDX_W'(idx)] == key) begin
                  hit        = 1'b1;
                  r.slot     = IDX_W'(idx);
                  r.position = IDX_W'(i);
               end
               idx = wrap_advance(idx, lim);
            end
            if (!hit)
               r.status = STAT_NOT_FOUND;
         end
         default: ;
      endcase
      r.count    = CNT_W'(ring_fill);
      r.is_empty = (ring_fill == 0);
      r.is_full  = (ring_fill == lim);
      return r;
   endfunction

   task automatic log_mismatch(input string msg);
      $display("[%0t] MISMATCH %s", $time, msg);
      fail_count++;
   endtask

   task automatic compare_result(input fifo_result_type want);
      if (rsp_status !== want.status)
         log_mismatch($sformatf("status got %0d want %0d", rsp_status, want.status));
      if (rsp_data_out !== want.data_out)
         log_mismatch($sformatf("data_out got %h want %h", rsp_data_out, want.data_out));
      if (rsp_found_slot !== want.slot)
         log_mismatch($sformatf("found_slot got %0d want %0d", rsp_found_slot, want.slot));
      if (rsp_found_position !== want.position)
         log_mismatch($sformatf("found_position got %0d want %0d",
                                rsp_found_position, want.position));
      if (rsp_count !== want.count)
         log_mismatch($sformatf("count got %0d want %0d", rsp_count, want.count));
      if (rsp_is_empty !== want.is_empty)
         log_mismatch($sformatf("is_empty got %b want %b", rsp_is_empty, want.is_empty));
      if (rsp_is_full !== want.is_full)
         log_mismatch($sformatf("is_full got %b want %b", rsp_is_full, want.is_full));
   endtask

   // Response first: an item taken at this edge answers at a later edge.
   always @(posedge clock) begin
      if (reset) begin
         ring_head    = 0;
         ring_tail    = 0;
         ring_fill    = 0;
         capacity_reg = CNT_W'(DEPTH);
      end else begin
         if (rsp_strobe === 1'b1) begin
            if (awaited_results.size() == 0)
               log_mismatch("response with no request outstanding");
            else
               compare_result(awaited_results.pop_front());
         end
         if (csr_wen) begin
            capacity_reg = csr_wdata;
            ring_head    = 0;
            ring_tail    = 0;
            ring_fill    = 0;
         end
         if (start && !busy)
            awaited_results.push_back(apply_request(req_action, req_value));
      end
      pending = awaited_results.size();
   end

endmodule

### tb/tb_searchable_ring_fifo.sv
// tb_searchable_ring_fifo: stimulus and verdict for the searchable ring FIFO.
// Depends on srf_pkg, searchable_ring_fifo and searchable_ring_fifo_checker.
module tb_searchable_ring_fifo;
   timeunit 1ns;
   timeprecision 1ps;
   import srf_pkg::*;

   localparam int              RANDOM_ITEMS     = 1530;
   localparam int              WATCHDOG_LIMIT   = 2000;
   // Codes 5..7 are unused actions; the block must leave the queue alone.
   localparam logic [ACT_W-1:0] ACT_FIRST_UNUSED = 3'd5;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [ACT_W-1:0]          req_action = ACT_ENQUEUE;
   logic signed [WORD_W-1:0]  req_value  = '0;
   logic                      rsp_strobe;
   logic [STAT_W-1:0]         rsp_status;
   logic signed [WORD_W-1:0]  rsp_data_out;
   logic [IDX_W-1:0]          rsp_found_slot;
   logic [IDX_W-1:0]          rsp_found_position;
   logic [CNT_W-1:0]          rsp_count;
   logic                      rsp_is_empty;
   logic                      rsp_is_full;
   logic                      csr_wen   = 1'b0;
   logic [CNT_W-1:0]          csr_wdata = '0;

   int                        pending;
   int                        fail_count;
   int                        quiet_cycles = 0;

   always #5 clock = ~clock;

   searchable_ring_fifo DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_value          (req_value),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_data_out       (rsp_data_out),
      .rsp_found_slot     (rsp_found_slot),
      .rsp_found_position (rsp_found_position),
      .rsp_count          (rsp_count),
      .rsp_is_empty       (rsp_is_empty),
      .rsp_is_full        (rsp_is_full),
      .csr_wen            (csr_wen),
      .csr_wdata          (csr_wdata)
   );

   searchable_ring_fifo_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_value          (req_value),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_data_out       (rsp_data_out),
      .rsp_found_slot     (rsp_found_slot),
      .rsp_found_position (rsp_found_position),
      .rsp_count          (rsp_count),
      .rsp_is_empty       (rsp_is_empty),
      .rsp_is_full        (rsp_is_full),
      .csr_wen            (csr_wen),
      .csr_wdata          (csr_wdata),
      .pending            (pending),
      .fail_count         (fail_count)
   );

   // Watchdog: a stretch with no item taken and no result seen means a hang.
   // The longest legal quiet stretch is a search plus a gap.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("searchable_ring_fifo verification failed");
            $finish;
         end
      end
   end

   // Present one item at the falling edge and hold it until the block takes
   // it. Returns right after the accepting edge with start still high; the
   // caller's next step begins at a falling edge, so start is only written
   // once per step.
   task automatic send_item(input logic [ACT_W-1:0] act,
                            input logic signed [WORD_W-1:0] val);
      @(negedge clock);
      start      <= 1'b1;
      req_action <= act;
      req_value  <= val;
      @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   task automatic idle_cycles(input int n);
      @(negedge clock);
      start <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // Stop sending and wait until every outstanding result has come back.
   task automatic drain_queue();
      @(negedge clock);
      start <= 1'b0;
      while (pending != 0)
         @(negedge clock);
   endtask

   // Capacity is written only when the block is quiet. Every item answers,
   // so the task waits for an empty result queue and then idles before the write.
   task automatic write_capacity(input logic [CNT_W-1:0] cap);
      drain_queue();
      repeat (2) @(negedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= cap;
      @(negedge clock);
      csr_wen   <= 1'b0;
   endtask

   // Drawn from a small pool of keys so searches hit and find duplicates,
   // plus the signed extremes, zero, all ones and fully random words.
   function automatic logic signed [WORD_W-1:0] pick_value();
      case ($urandom_range(9))
         0:       return {1'b1, {(WORD_W-1){1'b0}}};
         1:       return {1'b0, {(WORD_W-1){1'b1}}};
         2:       return '0;
         3:       return '1;
         4, 5, 6: return WORD_W'($urandom_range(7));
         default: return WORD_W'($urandom);
      endcase
   endfunction

   // enq_pct steers the fill level so the queue both fills up and drains.
   function automatic logic [ACT_W-1:0] pick_action(input int enq_pct);
      int r;
      if ($urandom_range(99) < enq_pct)
         return ACT_ENQUEUE;
      r = $urandom_range(99);
      if (r < 40) return ACT_DEQUEUE;
      if (r < 55) return ACT_PEEK;
      if (r < 91) return ACT_SEARCH;
      if (r < 94) return ACT_CLEAR;
      return ACT_W'(ACT_FIRST_UNUSED + $urandom_range(2));
   endfunction

   // Directed corner cases: empty refusals, signed extremes, duplicate keys,
   // misses, unused codes, clear, and a one-slot queue.
   task automatic run_directed();
      send_item(ACT_PEEK,    '0);
      send_item(ACT_DEQUEUE, '0);
      send_item(ACT_SEARCH,  '0);                          // search on empty
      send_item(ACT_ENQUEUE, {1'b1, {(WORD_W-1){1'b0}}});
      send_item(ACT_ENQUEUE, {1'b0, {(WORD_W-1){1'b1}}});
      send_item(ACT_ENQUEUE, '0);
      send_item(ACT_ENQUEUE, '1);
      send_item(ACT_ENQUEUE, {1'b0, {(WORD_W-1){1'b1}}}); // duplicate key
      send_item(ACT_SEARCH,  {1'b0, {(WORD_W-1){1'b1}}}); // first of two
      send_item(ACT_SEARCH,  '1);
      send_item(ACT_SEARCH,  32'sd12345);                 // miss
      send_item(ACT_PEEK,    '0);
      send_item(ACT_FIRST_UNUSED, '1);
      send_item(ACT_W'(ACT_FIRST_UNUSED + 2), '0);
      send_item(ACT_DEQUEUE, '0);
      send_item(ACT_CLEAR,   '1);
      send_item(ACT_DEQUEUE, '0);
      // one slot: second enqueue refused as full
      write_capacity(CNT_W'(1));
      send_item(ACT_ENQUEUE, 32'sd42);
      send_item(ACT_ENQUEUE, 32'sd43);
      send_item(ACT_SEARCH,  32'sd42);
      send_item(ACT_PEEK,    '0);
      send_item(ACT_DEQUEUE, '0);
      send_item(ACT_W'(ACT_FIRST_UNUSED + 1), 32'sd7);
   endtask

   // One capacity setting: bursts of random length with random gaps, some
   // bursts back to back, and one full drain midway.
   task automatic run_phase(input int n_items);
      int sent;
      int burst;
      int enq_pct;
      sent    = 0;
      enq_pct = 50;
      while (sent < n_items) begin
         burst = $urandom_range(1, 16);
         for (int b = 0; b < burst && sent < n_items; b++) begin
            // pick a new fill bias every 40 items: drain, hold or fill
            if (sent % 40 == 0)
               enq_pct = ($urandom_range(2) == 0) ? 25 :
                         ($urandom_range(1) == 0) ? 50 : 75;
            send_item(pick_action(enq_pct), pick_value());
            sent++;
            if (sent == n_items / 2)
               drain_queue();
         end
         if ($urandom_range(3) != 0)
            idle_cycles($urandom_range(1, 8));
      end
   endtask

   initial begin
      logic [CNT_W-1:0] caps [8];
      int               per_phase;
      // Capacities: DEPTH, all ones (clamped to DEPTH), zero (acts as one), just
      // above DEPTH, a random size in between, and the small sizes 5 and 2.
      caps[0] = CNT_W'(DEPTH);
      caps[1] = '1;
      caps[2] = CNT_W'(5);
      caps[3] = '0;
      caps[4] = CNT_W'(DEPTH + 1);
      caps[5] = CNT_W'($urandom_range(2, DEPTH - 1));
      caps[6] = CNT_W'(2);
      caps[7] = CNT_W'(DEPTH);
      per_phase = RANDOM_ITEMS / 8;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();
      foreach (caps[i]) begin
         write_capacity(caps[i]);
         run_phase(per_phase);
      end

      drain_queue();
      // Room for a late or stray result after the last one due.
      repeat (DEPTH + 4) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("searchable_ring_fifo verification clean");
      else
         $display("searchable_ring_fifo verification failed");
      $finish;
   end

endmodule

### sim.f
src/srf_pkg.sv
src/srf_cell.sv
src/searchable_ring_fifo.sv
tb/searchable_ring_fifo_checker.sv
tb/tb_searchable_ring_fifo.sv
